/* src/psa_pkg.sv */
// Shared types and codes for the page span allocator.
// No dependencies.
`default_nettype none
package psa_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSIZE = 2'd1;
  localparam logic [1:0] ST_EXHAUST = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  localparam logic [7:0] CFG_POOL_BASE    = 8'd0;
  localparam logic [7:0] CFG_REGION_LIMIT = 8'd1;

  localparam int SCAN_WIN = 8;

  typedef struct packed {
    logic capture;
    logic scan;
    logic fresh;
    logic pop_a;
    logic pop_b;
    logic pop_c;
    logic bad;
    logic exhaust;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic found;
    logic scan_end;
    logic exhausted;
  } sts_t;

endpackage
`default_nettype wire

/* src/psa_ctrl.sv */
// Controller state machine of the page span allocator.
// Depends on psa_pkg.
`default_nettype none
module psa_ctrl import psa_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FRESH = 3'd2;
  localparam logic [2:0] S_POPA  = 3'd3;
  localparam logic [2:0] S_POPB  = 3'd4;
  localparam logic [2:0] S_POPC  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.bad_size) begin
            cmd.bad   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = S_POPA;
        end else if (sts.scan_end) begin
          if (sts.exhausted) begin
            cmd.exhaust = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            state_nxt = S_FRESH;
          end
        end
      end
      S_FRESH: begin
        cmd.fresh = 1'b1;
        state_nxt = S_POPA;
      end
      S_POPA: begin
        cmd.pop_a = 1'b1;
        state_nxt = S_POPB;
      end
      S_POPB: begin
        cmd.pop_b = 1'b1;
        state_nxt = S_POPC;
      end
      S_POPC: begin
        cmd.pop_c = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule
`default_nettype wire

/* src/psa_dp.sv */
// Datapath of the page span allocator: bucket stacks, fill counts, scan, split.
// Depends on psa_pkg.
`default_nettype none
module psa_dp import psa_pkg::*; #(
  parameter int NUM_BUCKETS  = 128,
  parameter int STACK_DEPTH  = 16,
  parameter int PAGE_ID_BITS = 40
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire  [7:0]              in_requested_pages,
  input  wire                     cfg_we,
  input  wire  [7:0]              cfg_index,
  input  wire  [39:0]             cfg_data,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [PAGE_ID_BITS-1:0] out_start_page,
  output logic [6:0]              out_page_count,
  output logic [1:0]              out_status
);

  localparam int BW  = $clog2(NUM_BUCKETS);
  localparam int SW  = BW + 1;
  localparam int FW  = $clog2(STACK_DEPTH + 1);
  localparam int SLW = $clog2(STACK_DEPTH);
  localparam int AW  = $clog2(NUM_BUCKETS * STACK_DEPTH);
  localparam int PW  = PAGE_ID_BITS;

  logic [15:0]     limit_r;
  logic [PW-1:0]   fresh_r;
  logic [15:0]     used_r;
  logic [NUM_BUCKETS-1:0] nonempty_r;
  logic [BW-1:0]   pages_r;
  logic [SW-1:0]   scan_r;
  logic [BW-1:0]   bkt_r;
  logic [FW-1:0]   fill_q_r;
  logic [PW-1:0]   stk_q_r;
  logic [PW-1:0]   start_r;
  logic [6:0]      count_r;
  logic [1:0]      status_r;

  logic [FW-1:0]   fill_mem [NUM_BUCKETS];
  logic [PW-1:0]   stk_mem  [NUM_BUCKETS*STACK_DEPTH];

  logic [NUM_BUCKETS-1:0] win_full;
  logic [SCAN_WIN-1:0]    win;
  logic [2:0]      pe;
  logic [BW-1:0]   rem;
  logic [FW-1:0]   fill_dec;
  logic [FW-1:0]   rem_fill;
  logic            push_ok;
  logic [AW-1:0]   pop_addr, push_addr, fresh_addr;
  logic [BW-1:0]   fill_rd_addr;
  logic [PW-1:0]   split_page;

  always_comb begin
    win_full = nonempty_r >> scan_r;
    win      = win_full[SCAN_WIN-1:0];
    pe       = '0;
    for (int k = SCAN_WIN - 1; k >= 0; k--) begin
      if (win[k]) pe = 3'(k);
    end
  end

  assign sts.bad_size  = (in_requested_pages == 8'd0) ||
                         ({1'b0, in_requested_pages} >= 9'(NUM_BUCKETS));
  assign sts.found     = (win != '0);
  assign sts.scan_end  = (32'(scan_r) + SCAN_WIN >= NUM_BUCKETS);
  assign sts.exhausted = (used_r >= limit_r);

  assign rem        = bkt_r - pages_r;
  assign fill_dec   = fill_q_r - FW'(1);
  assign rem_fill   = nonempty_r[rem] ? fill_q_r : '0;
  assign push_ok    = (32'(rem_fill) < STACK_DEPTH);
  assign split_page = stk_q_r + PW'(pages_r);
  assign pop_addr   = AW'(bkt_r) * AW'(STACK_DEPTH) + AW'(fill_dec[SLW-1:0]);
  assign push_addr  = AW'(rem) * AW'(STACK_DEPTH) + AW'(rem_fill[SLW-1:0]);
  assign fresh_addr = AW'(NUM_BUCKETS - 1) * AW'(STACK_DEPTH);
  assign fill_rd_addr = cmd.pop_b ? rem : bkt_r;

  always_ff @(posedge clk) begin
    fill_q_r <= fill_mem[fill_rd_addr];
    stk_q_r  <= stk_mem[pop_addr];
    if (cmd.fresh) begin
      fill_mem[BW'(NUM_BUCKETS - 1)] <= FW'(1);
      stk_mem[fresh_addr]            <= fresh_r;
    end else if (cmd.pop_b) begin
      fill_mem[bkt_r] <= fill_dec;
    end else if (cmd.pop_c && (bkt_r != pages_r) && push_ok) begin
      fill_mem[rem]        <= rem_fill + FW'(1);
      stk_mem[push_addr]   <= split_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= 16'd16;
      fresh_r    <= '0;
      used_r     <= '0;
      nonempty_r <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_POOL_BASE) begin
        if (used_r == '0) fresh_r <= PW'(cfg_data);
      end
      if (cfg_we && cfg_index == CFG_REGION_LIMIT) limit_r <= cfg_data[15:0];
      if (cmd.fresh) begin
        nonempty_r[NUM_BUCKETS-1] <= 1'b1;
        fresh_r <= fresh_r + PW'(NUM_BUCKETS - 1);
        used_r  <= used_r + 16'd1;
      end
      if (cmd.pop_b && fill_dec == '0) nonempty_r[bkt_r] <= 1'b0;
      if (cmd.pop_c && (bkt_r != pages_r) && push_ok) nonempty_r[rem] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pages_r <= in_requested_pages[BW-1:0];
      scan_r  <= SW'(in_requested_pages[BW-1:0]);
    end else if (cmd.scan) begin
      scan_r <= scan_r + SW'(SCAN_WIN);
    end
    if (cmd.scan)  bkt_r <= BW'(scan_r + SW'(pe));
    if (cmd.fresh) bkt_r <= BW'(NUM_BUCKETS - 1);
    if (cmd.bad || cmd.exhaust) begin
      start_r  <= '0;
      count_r  <= '0;
      status_r <= cmd.bad ? ST_BADSIZE : ST_EXHAUST;
    end else if (cmd.pop_c) begin
      start_r  <= stk_q_r;
      count_r  <= 7'(pages_r);
      status_r <= ((bkt_r != pages_r) && !push_ok) ? ST_DROPPED : ST_OK;
    end
  end

  assign out_start_page = start_r;
  assign out_page_count = count_r;
  assign out_status     = status_r;

endmodule
`default_nettype wire

/* src/page_span_allocator_core.sv */
// Top level of the page span allocator: controller plus datapath.
// Depends on psa_pkg, psa_ctrl, psa_dp.
//
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | in_requested_pages
// out     | output    | out_valid/stall | out_start_page, out_page_count, out_status
// cfg     | input     | cfg_valid/ready | cfg_index, cfg_data
//
// One item at a time: a bad size goes straight to the result. Otherwise the scan
// steps over windows of 8 buckets from the requested size upward; if none is found
// the result is refused when the pool is exhausted, else a fresh region is taken;
// then pop and split follow. The result is held while out_stall is high.
// Reset clears the nonempty flags and the used and fresh counters and sets the region limit to 16; no clearing pass.
// in_stall stays high from acceptance until the result item is taken.
`default_nettype none
module page_span_allocator_core import psa_pkg::*; #(
  parameter int NUM_BUCKETS  = 128,
  parameter int STACK_DEPTH  = 16,
  parameter int PAGE_ID_BITS = 40
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [7:0]              in_requested_pages,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [PAGE_ID_BITS-1:0] out_start_page,
  output logic [6:0]              out_page_count,
  output logic [1:0]              out_status,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [7:0]              cfg_index,
  input  wire  [39:0]             cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  psa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  psa_dp #(
    .NUM_BUCKETS(NUM_BUCKETS), .STACK_DEPTH(STACK_DEPTH), .PAGE_ID_BITS(PAGE_ID_BITS)
  ) u_dp (
    .clk, .rst_n, .in_requested_pages,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .cmd, .sts, .out_start_page, .out_page_count, .out_status
  );

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BADSIZE || out_status == ST_EXHAUST) |->
      out_page_count == 7'd0 && out_start_page == '0)
    else $error("refused item carries a grant");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_DROPPED) |->
      out_page_count != 7'd0) else $error("grant of zero pages");

endmodule
`default_nettype wire
